FILE: rtl/greedy_change_dispenser_top_macros.svh
// assertion helpers for the change dispenser
`ifndef GREEDY_CHANGE_DISPENSER_TOP_MACROS_SVH
`define GREEDY_CHANGE_DISPENSER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define GCHG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define GCHG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/gchg_pkg.sv
package gchg_pkg;

    localparam int AMOUNT_W   = 32;
    localparam int COIN_W     = 20;
    localparam int COUNT_W    = 32;
    localparam int TOTAL_W    = 48;
    localparam int STATUS_W   = 2;
    localparam int CUR_W      = 2;
    localparam int CUR_N      = 4;
    localparam int TBL_SLOTS  = 16;
    localparam int MAX_DENOMS = 14;
    localparam int SLOT_W     = $clog2(TBL_SLOTS);
    localparam int IDX_W      = $clog2(TBL_SLOTS + 1);
    localparam int STEP_W     = $clog2(AMOUNT_W);
    localparam int APB_W      = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = PADDR_W - 2;

    // result codes
    localparam logic [STATUS_W-1:0] STATUS_COIN   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EXACT  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SHORT  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_TOTAL  = 2'd3;

    // request codes
    localparam logic OP_SALE  = 1'b0;
    localparam logic OP_CLOSE = 1'b1;

    // register map
    localparam logic [REG_IDX_W-1:0] REG_CURRENCY = '0;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // ascending denominations per currency, thousandths of a unit
    localparam logic [COIN_W-1:0] DENOM_TBL [CUR_N][TBL_SLOTS] = '{
        '{20'd250, 20'd500, 20'd1000, 20'd5000, 20'd10000, 20'd20000, 20'd50000,
          20'd100000, 20'd200000, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0},
        '{20'd10, 20'd50, 20'd100, 20'd250, 20'd500, 20'd1000, 20'd2000, 20'd5000,
          20'd10000, 20'd20000, 20'd50000, 20'd100000, 20'd200000, 20'd500000,
          20'd0, 20'd0},
        '{20'd10, 20'd50, 20'd100, 20'd250, 20'd500, 20'd1000, 20'd5000, 20'd10000,
          20'd20000, 20'd50000, 20'd100000, 20'd200000, 20'd500000, 20'd1000000,
          20'd0, 20'd0},
        '{20'd1, 20'd5, 20'd10, 20'd20, 20'd50, 20'd100, 20'd250, 20'd500,
          20'd1000, 20'd5000, 20'd10000, 20'd20000, 20'd0, 20'd0, 20'd0, 20'd0}
    };

    localparam logic [IDX_W-1:0] DENOM_LEN [CUR_N] = '{5'd9, 5'd14, 5'd14, 5'd12};

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COIN_W-1:0]   coin_value;
        logic [COUNT_W-1:0]  coin_count;
        logic [TOTAL_W-1:0]  day_total;
        logic                last;
    } t_result;

    function automatic logic [COIN_W-1:0] denom_value(
        input logic [CUR_W-1:0]  cur,
        input logic [SLOT_W-1:0] slot
    );
        return DENOM_TBL[cur][slot];
    endfunction

    // table length clipped to the configured maximum
    function automatic logic [IDX_W-1:0] denom_count(input logic [CUR_W-1:0] cur);
        logic [IDX_W-1:0] len;
        len = DENOM_LEN[cur];
        if (len > IDX_W'(MAX_DENOMS)) begin
            len = IDX_W'(MAX_DENOMS);
        end
        return len;
    endfunction

endpackage

FILE: rtl/greedy_change_dispenser_top.sv
// Greedy change dispenser. A sale beat carries a price and the amount paid, both
// in thousandths of a unit; a close-day beat reports the saturating 48-bit day
// total and clears it. Short payment gives one insufficient result, exact payment
// one exact result, and overpayment one coin result per denomination used,
// largest first, with o_last set on the final result of each request. If the
// change is below the smallest coin a single coin result with zero value and
// count is given. The currency register (byte address 0) picks the table; the user
// must write it only while the block is idle, which the block does not enforce.
// Rate: the block takes one request at a time and holds o_in_stall from acceptance
// until its last result has been loaded into the output register. Close-day, short
// and exact requests go from idle straight to the emit state. An overpaid sale
// scans the table from its largest denomination down, skipping each that does not
// fit and dividing the change by each that does in the single restoring divider,
// one quotient bit per cycle over 32 bits, shared by all denominations. An output
// stall holds the block in its emit state.
`include "greedy_change_dispenser_top_macros.svh"

module greedy_change_dispenser_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_opcode,
    input  logic [gchg_pkg::AMOUNT_W-1:0]  i_price,
    input  logic [gchg_pkg::AMOUNT_W-1:0]  i_paid,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [gchg_pkg::STATUS_W-1:0]  o_status,
    output logic [gchg_pkg::COIN_W-1:0]    o_coin_value,
    output logic [gchg_pkg::COUNT_W-1:0]   o_coin_count,
    output logic [gchg_pkg::TOTAL_W-1:0]   o_day_total,
    output logic                           o_last,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gchg_pkg::PADDR_W-1:0]   paddr,
    input  logic [gchg_pkg::APB_W-1:0]     pwdata,
    output logic [gchg_pkg::APB_W-1:0]     prdata,
    output logic                           pready
);
    import gchg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_FIN,
        S_EMIT
    } t_state;

    t_state                r_state;
    t_state                r_ret_state;   // where to go after the result is loaded
    logic [CUR_W-1:0]      r_currency;
    logic [TOTAL_W-1:0]    r_takings;
    logic [AMOUNT_W-1:0]   r_rem;         // change still to hand out
    logic [IDX_W-1:0]      r_idx;         // denominations left to try
    logic                  r_found;       // a coin result was already given
    logic [COIN_W-1:0]     r_coin;
    logic [AMOUNT_W-1:0]   r_div_q;       // dividend in, quotient out
    logic [COIN_W-1:0]     r_div_r;       // partial remainder
    logic [STEP_W-1:0]     r_step;
    t_result               r_res;         // result waiting for the output register
    logic                  r_out_valid;
    t_result               r_out;

    logic                  in_accept;
    logic                  out_free;
    logic                  cfg_write;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic [IDX_W-1:0]      idx_dec;
    logic [COIN_W-1:0]     scan_coin;
    logic [COIN_W-1:0]     min_coin;
    logic [COIN_W:0]       div_trial;
    logic [COIN_W:0]       div_diff;
    logic                  div_ge;
    logic [TOTAL_W:0]      takings_sum;
    logic [TOTAL_W-1:0]    takings_sat;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[PADDR_W-1:2];

    // denomination under test during the scan
    assign idx_dec   = r_idx - IDX_W'(1);
    assign scan_coin = denom_value(r_currency, idx_dec[SLOT_W-1:0]);
    assign min_coin  = denom_value(r_currency, '0);

    // one restoring division step: shift in the next dividend bit, try subtract
    assign div_trial = {r_div_r, r_div_q[AMOUNT_W-1]};
    assign div_diff  = div_trial - {1'b0, r_coin};
    assign div_ge    = div_trial >= {1'b0, r_coin};

    // saturating day total
    assign takings_sum = {1'b0, r_takings} + (TOTAL_W + 1)'(i_price);
    assign takings_sat = takings_sum[TOTAL_W] ? TOTAL_MAX : takings_sum[TOTAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret_state <= S_IDLE;
            r_currency  <= '0;
            r_takings   <= '0;
            r_rem       <= '0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_write && reg_idx == REG_CURRENCY) begin
                r_currency <= pwdata[CUR_W-1:0];
            end

            // output register: load a pending result or drain on acceptance
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
                r_out       <= r_res;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_res.coin_value <= '0;
                        r_res.coin_count <= '0;
                        r_res.day_total  <= (i_opcode == OP_CLOSE) ? r_takings : '0;
                        r_res.last       <= 1'b1;
                        r_ret_state      <= S_IDLE;
                        if (i_opcode == OP_CLOSE) begin
                            r_res.status    <= STATUS_TOTAL;
                            r_takings       <= '0;
                            r_state         <= S_EMIT;
                        end else if (i_paid < i_price) begin
                            r_res.status <= STATUS_SHORT;
                            r_state      <= S_EMIT;
                        end else begin
                            r_takings <= takings_sat;
                            if (i_paid == i_price) begin
                                r_res.status <= STATUS_EXACT;
                                r_state      <= S_EMIT;
                            end else begin
                                r_rem   <= i_paid - i_price;
                                r_idx   <= denom_count(r_currency);
                                r_found <= 1'b0;
                                r_state <= S_SCAN;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (r_idx == '0) begin
                        // change below the smallest coin: one empty coin result
                        r_res.status     <= STATUS_COIN;
                        r_res.coin_value <= '0;
                        r_res.coin_count <= '0;
                        r_res.day_total  <= '0;
                        r_res.last       <= 1'b1;
                        r_ret_state      <= S_IDLE;
                        r_state          <= r_found ? S_IDLE : S_EMIT;
                    end else if (scan_coin == '0 || r_rem < AMOUNT_W'(scan_coin)) begin
                        r_idx <= idx_dec;
                    end else begin
                        r_coin  <= scan_coin;
                        r_div_q <= r_rem;
                        r_div_r <= '0;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_div_r <= div_ge ? div_diff[COIN_W-1:0] : div_trial[COIN_W-1:0];
                    r_div_q <= {r_div_q[AMOUNT_W-2:0], div_ge};
                    r_step  <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(AMOUNT_W - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // the smallest coin fits iff any later denomination fits
                    r_res.status     <= STATUS_COIN;
                    r_res.coin_value <= r_coin;
                    r_res.coin_count <= COUNT_W'(r_div_q);
                    r_res.day_total  <= '0;
                    r_res.last       <= r_div_r < min_coin;
                    r_rem            <= AMOUNT_W'(r_div_r);
                    r_idx            <= idx_dec;
                    r_found          <= 1'b1;
                    r_ret_state      <= (r_div_r < min_coin) ? S_IDLE : S_SCAN;
                    r_state          <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= r_ret_state;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = r_state != S_IDLE;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out.status;
    assign o_coin_value = r_out.coin_value;
    assign o_coin_count = r_out.coin_count;
    assign o_day_total  = r_out.day_total;
    assign o_last       = r_out.last;

    assign pready = 1'b1;
    assign prdata = (reg_idx == REG_CURRENCY) ? APB_W'(r_currency) : '0;

    // non-coin results always end their request
    `GCHG_ASSERT_NOW(a_single_last, o_out_valid && o_status != STATUS_COIN, o_last, "non-coin result without last")
    // day total only travels on close-day results
    `GCHG_ASSERT_NOW(a_total_only, o_out_valid && o_status != STATUS_TOTAL, o_day_total == '0, "day total on wrong result")
    // partial remainder stays below the divisor
    `GCHG_ASSERT_NOW(a_div_bound, r_state == S_DIV, r_div_r < r_coin, "divider remainder out of range")
    // close day leaves an empty total
    `GCHG_ASSERT_NEXT(a_close_clear, in_accept && i_opcode == OP_CLOSE, r_takings == '0, "takings not cleared")

endmodule

FILE: sim/greedy_change_dispenser_top_test.sv
module greedy_change_dispenser_top_test;
    import gchg_pkg::*;

    // currency codes for the currency register
    localparam logic [CUR_W-1:0] CUR_EGY = 2'd0;
    localparam logic [CUR_W-1:0] CUR_KSA = 2'd1;
    localparam logic [CUR_W-1:0] CUR_UAE = 2'd2;
    localparam logic [CUR_W-1:0] CUR_KWT = 2'd3;

    // byte addresses: the currency register and an unmapped slot above it
    localparam logic [PADDR_W-1:0] ADDR_CURRENCY = {REG_CURRENCY, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_SPARE    = {~REG_CURRENCY, 2'b00};

    // coin tables, ascending, in thousandths; unused slots are zero
    localparam logic [AMOUNT_W-1:0] CHANGE_COINS [CUR_N][TBL_SLOTS] = '{
        '{250, 500, 1000, 5000, 10000, 20000, 50000, 100000, 200000,
          0, 0, 0, 0, 0, 0, 0},
        '{10, 50, 100, 250, 500, 1000, 2000, 5000, 10000, 20000, 50000, 100000,
          200000, 500000, 0, 0},
        '{10, 50, 100, 250, 500, 1000, 5000, 10000, 20000, 50000, 100000, 200000,
          500000, 1000000, 0, 0},
        '{1, 5, 10, 20, 50, 100, 250, 500, 1000, 5000, 10000, 20000,
          0, 0, 0, 0}
    };
    localparam int CHANGE_COIN_N [CUR_N] = '{9, 14, 14, 12};

    // results that can be read off directly
    localparam t_result PAID_SHORT = '{STATUS_SHORT, 20'd0, 32'd0, 48'd0, 1'b1};
    localparam t_result PAID_EXACT = '{STATUS_EXACT, 20'd0, 32'd0, 48'd0, 1'b1};
    localparam t_result NO_COIN    = '{STATUS_COIN, 20'd0, 32'd0, 48'd0, 1'b1};
    localparam t_result EMPTY_DAY  = '{STATUS_TOTAL, 20'd0, 32'd0, 48'd0, 1'b1};
    localparam t_result PREDICTED  = '0;

    typedef struct packed {
        logic                op;
        logic [AMOUNT_W-1:0] price;
        logic [AMOUNT_W-1:0] paid;
        logic                typed;
        t_result             want;
    } t_row;

    // directed beats, currency at its reset value
    localparam int DIRECTED_N = 19;
    localparam t_row DIRECTED [DIRECTED_N] = '{
        // nothing sold yet, price and paid ignored
        '{OP_CLOSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, EMPTY_DAY},
        '{OP_SALE, 32'd0, 32'd0, 1'b1, PAID_EXACT},
        '{OP_SALE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, PAID_EXACT},
        '{OP_SALE, 32'd1, 32'd0, 1'b1, PAID_SHORT},
        '{OP_SALE, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, PAID_SHORT},
        '{OP_SALE, 32'hFFFF_FFFF, 32'd0, 1'b1, PAID_SHORT},
        // only the one full-price exact sale counts
        '{OP_CLOSE, 32'd0, 32'd0, 1'b1,
          '{STATUS_TOTAL, 20'd0, 32'd0, 48'h0000_FFFF_FFFF, 1'b1}},
        // second close right after: cleared
        '{OP_CLOSE, 32'd0, 32'd0, 1'b1, EMPTY_DAY},
        // change below the smallest coin, then exactly the smallest and the largest coin
        '{OP_SALE, 32'd0, 32'd1, 1'b1, NO_COIN},
        '{OP_SALE, 32'd0, 32'd100, 1'b1, NO_COIN},
        '{OP_SALE, 32'd1000, 32'd1249, 1'b1, NO_COIN},
        '{OP_SALE, 32'd0, 32'd250, 1'b0, PREDICTED},
        '{OP_SALE, 32'd0, 32'd200000, 1'b0, PREDICTED},
        // every coin once plus a leftover
        '{OP_SALE, 32'd0, 32'd386999, 1'b0, PREDICTED},
        '{OP_SALE, 32'd0, 32'hFFFF_FFFF, 1'b0, PREDICTED},
        '{OP_SALE, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, PREDICTED},
        '{OP_SALE, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, PREDICTED},
        '{OP_SALE, 32'd12345, 32'd13095, 1'b0, PREDICTED},
        '{OP_CLOSE, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b0, PREDICTED}
    };

    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 63;
    localparam int MAX_GAP     = 20;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 600;

    // idling pattern per phase, repeated every four phases
    localparam int SEND_IDLE  [4] = '{0, 78, 0, 26};
    localparam int RECV_STALL [4] = '{0, 0, 78, 26};
    localparam logic [CUR_W-1:0] PHASE_CUR [PHASES] = '{
        CUR_KWT, CUR_EGY, CUR_KSA, CUR_UAE, CUR_KWT, CUR_UAE, CUR_EGY, CUR_KSA
    };

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                i_opcode     = OP_SALE;
    logic [AMOUNT_W-1:0] i_price      = '0;
    logic [AMOUNT_W-1:0] i_paid       = '0;
    logic                i_out_stall  = 1'b0;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [PADDR_W-1:0]  paddr        = '0;
    logic [APB_W-1:0]    pwdata       = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [STATUS_W-1:0] o_status;
    logic [COIN_W-1:0]   o_coin_value;
    logic [COUNT_W-1:0]  o_coin_count;
    logic [TOTAL_W-1:0]  o_day_total;
    logic                o_last;
    logic [APB_W-1:0]    prdata;
    logic                pready;

    // predictor state
    logic [CUR_W-1:0]    currency_sel = CUR_EGY;
    logic [TOTAL_W-1:0]  till_total   = '0;
    t_result             due_results [$];

    int mismatches = 0;
    int idle_pct   = 26;
    int stall_pct  = 26;
    bit hold_req   = 1'b0;
    int hold_left  = 0;

    greedy_change_dispenser_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_price      (i_price),
        .i_paid       (i_paid),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_coin_value (o_coin_value),
        .o_coin_count (o_coin_count),
        .o_day_total  (o_day_total),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // results one request gives: greedy split of the change, largest coin first
    function automatic void work_out_change(input logic op,
                                            input logic [AMOUNT_W-1:0] price,
                                            input logic [AMOUNT_W-1:0] paid);
        t_result             r;
        logic [TOTAL_W:0]    sum;
        logic [AMOUNT_W-1:0] rest;
        logic [AMOUNT_W-1:0] coin;
        logic [AMOUNT_W-1:0] cnt;
        int                  n;
        int                  used;
        r = '0;
        r.last = 1'b1;
        if (op == OP_CLOSE) begin
            r.status = STATUS_TOTAL;
            r.day_total = till_total;
            till_total = '0;
            due_results.push_back(r);
        end else if (paid < price) begin
            r.status = STATUS_SHORT;
            due_results.push_back(r);
        end else begin
            // saturating day total
            sum = {1'b0, till_total} + (TOTAL_W + 1)'(price);
            till_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
            if (paid == price) begin
                r.status = STATUS_EXACT;
                due_results.push_back(r);
            end else begin
                rest = paid - price;
                used = 0;
                n = CHANGE_COIN_N[currency_sel];
                if (n > MAX_DENOMS) begin
                    n = MAX_DENOMS;
                end
                for (int i = n - 1; i >= 0; i--) begin
                    coin = CHANGE_COINS[currency_sel][i];
                    if (coin != 0 && rest >= coin) begin
                        cnt = rest / coin;
                        rest = rest - cnt * coin;
                        r = '0;
                        r.status = STATUS_COIN;
                        r.coin_value = coin[COIN_W-1:0];
                        r.coin_count = cnt;
                        due_results.push_back(r);
                        used++;
                    end
                end
                // nothing fits: one empty coin beat
                if (used == 0) begin
                    r = '0;
                    r.status = STATUS_COIN;
                    r.last = 1'b1;
                    due_results.push_back(r);
                end else begin
                    due_results[due_results.size() - 1].last = 1'b1;
                end
            end
        end
    endfunction

    // offer one request beat, hold it until taken, then queue its results
    task automatic request(input logic op, input logic [AMOUNT_W-1:0] price,
                           input logic [AMOUNT_W-1:0] paid, input logic typed,
                           input t_result want);
        int gap;
        int before_n;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_price    <= price;
        i_paid     <= paid;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        before_n = due_results.size();
        work_out_change(op, price, paid);
        // typed-in rows replace what the predictor queued
        if (typed) begin
            while (due_results.size() > before_n) begin
                void'(due_results.pop_back());
            end
            due_results.push_back(want);
        end
    endtask

    // setup and access cycle; written at the access edge, then read back
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [CUR_W-1:0] cur);
        logic [APB_W-1:0] word;
        logic [APB_W-1:0] want_rd;
        word = $urandom;
        word[CUR_W-1:0] = cur;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_CURRENCY) begin
            currency_sel = cur;
        end
        @(posedge i_clk);
        want_rd = (addr == ADDR_CURRENCY) ? APB_W'(currency_sel) : '0;
        if (prdata !== want_rd) begin
            $display("%0t prdata mismatch: expected %0d, actual %0d", $time, want_rd, prdata);
            mismatches++;
        end
    endtask

    // block idle: every queued result taken
    task automatic wait_drained();
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_field(input string tag, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, tag, want, got);
            mismatches++;
        end
    endtask

    // result side: check the beat taken at this edge, then pick the next stall
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                $display("%0t unexpected result: expected none, actual status %0d value %0d",
                         $time, o_status, o_coin_value);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                check_field("status", want.status, o_status);
                check_field("coin_value", want.coin_value, o_coin_value);
                check_field("coin_count", want.coin_count, o_coin_count);
                check_field("day_total", want.day_total, o_day_total);
                check_field("last", want.last, o_last);
            end
        end
        // long hold-off so the block backs up into its input
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // main sequence
    initial begin
        logic                op;
        logic [AMOUNT_W-1:0] price;
        logic [AMOUNT_W-1:0] paid;
        logic [AMOUNT_W-1:0] change;
        int                  pick;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        for (int k = 0; k < DIRECTED_N; k++) begin
            request(DIRECTED[k].op, DIRECTED[k].price, DIRECTED[k].paid,
                    DIRECTED[k].typed, DIRECTED[k].want);
        end
        i_in_valid <= 1'b0;

        // random phases, one currency each
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            write_reg(ADDR_CURRENCY, PHASE_CUR[ph]);
            // unmapped register: must leave the currency alone
            if (ph == 4) begin
                write_reg(ADDR_SPARE, ~PHASE_CUR[ph]);
            end
            idle_pct  = SEND_IDLE[ph % 4];
            stall_pct = RECV_STALL[ph % 4];
            if (ph == 0) begin
                hold_req = 1'b1;
            end
            repeat (PHASE_BEATS) begin
                pick  = $urandom_range(99);
                op    = OP_SALE;
                price = $urandom;
                paid  = $urandom;
                if (pick < 5) begin
                    op = OP_CLOSE;
                end else if (pick < 20) begin
                    // short payment
                    if (price == 0) begin
                        price = 32'd1;
                    end
                    paid = $urandom % price;
                end else if (pick < 30) begin
                    paid = price;
                end else begin
                    // overpaid: mostly small or mid-size change
                    case ($urandom_range(2))
                        0: change = $urandom_range(300, 1);
                        1: change = $urandom_range(2000000, 1);
                        default: change = $urandom;
                    endcase
                    if (change == 0) begin
                        change = 32'd1;
                    end
                    if ($urandom_range(1) == 1) begin
                        price = $urandom_range(100000, 0);
                    end
                    if (price > ~change) begin
                        price = ~change;
                    end
                    paid = price + change;
                end
                request(op, price, paid, 1'b0, PREDICTED);
            end
            i_in_valid <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("PASS greedy_change_dispenser_top");
        end else begin
            $display("FAIL greedy_change_dispenser_top");
        end
        $finish;
    end

    // watchdog
    initial begin
        #16000000;
        $display("FAIL greedy_change_dispenser_top");
        $finish;
    end

endmodule
